>>> design/plil_pkg.sv
// Shared types and constants for the positional list block.
// No dependencies; imported by plil_out_stage and positional_list_insert_remove.
package plil_pkg;

	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int POS_W  = 7;
	localparam int CMP_W  = 8;
	localparam int ID_W   = 32;
	localparam int YEAR_W = 16;

	localparam logic CMD_INSERT    = 1'b0;
	localparam logic CMD_REMOVE    = 1'b1;
	localparam logic STATUS_DONE   = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FLUSH,
		ST_PUT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic signed [ID_W-1:0] isbn;
		logic [YEAR_W-1:0]      year;
	} record_t;

	typedef struct packed {
		logic                   status;
		logic                   has_entry;
		logic [POS_W-1:0]       list_index;
		logic signed [ID_W-1:0] isbn;
		logic [YEAR_W-1:0]      year;
		logic                   last;
	} result_t;

endpackage

>>> design/positional_list_insert_remove.sv
// Top level of the positional list: sequencer, record memory, stream ports.
// Depends on plil_pkg and plil_out_stage.
//
// Holds an ordered list of up to DEPTH records in one memory with a single
// read and a single write port (registered read data). One command is
// taken at a time. A command that is carried out moves each record behind
// the position by one place (count - position + 1 records for insert,
// count - position for remove), flushes the last move after any move, writes
// an inserted record, and then streams max(count, 1) result items at one per
// cycle when the sink keeps ready high. A new command is taken in the cycle
// after the last result item enters the output register.
module positional_list_insert_remove (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // position[6:0], entry_isbn[38:7], entry_year[54:39], zero
	input  logic [0:0]  s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // list_index[6:0], out_isbn[38:7], out_year[54:39], zero
	output logic [1:0]  m_tuser,  // status, has_entry
	output logic        m_tlast
);
	import plil_pkg::*;

	state_t state_q, state_d;

	record_t mem_q [DEPTH];
	record_t rdata_q;

	logic                   cmd_q;
	logic                   status_q;
	logic [ADDR_W-1:0]      put_addr_q;
	logic signed [ID_W-1:0] isbn_q;
	logic [YEAR_W-1:0]      year_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [ADDR_W-1:0]      rd_ptr_q;
	logic [ADDR_W-1:0]      rd_end_q;
	logic [CNT_W-1:0]       emit_ptr_q;

	logic              wr_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              pend_s1;
	logic [POS_W-1:0]  idx_s1;
	logic              last_s1;

	logic                   in_cmd;
	logic [POS_W-1:0]       in_pos;
	logic signed [ID_W-1:0] in_isbn;
	logic [YEAR_W-1:0]      in_year;
	logic                   accept;

	logic [CMP_W-1:0] pos_ext, cnt_ext, cnt_m1, pos_m1;
	logic             ins_ok, rem_ok, do_moves;

	logic              rd_en, we, load, free, emit_issue, emit_done;
	logic [ADDR_W-1:0] rd_addr, waddr;
	record_t           wdata;
	result_t           res_d, res_q;

	assign in_pos  = s_tdata[6:0];
	assign in_isbn = s_tdata[38:7];
	assign in_year = s_tdata[54:39];
	assign in_cmd  = s_tuser[0];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign pos_ext = CMP_W'(in_pos);
	assign cnt_ext = CMP_W'(cnt_q);
	assign cnt_m1  = cnt_ext - CMP_W'(1);
	assign pos_m1  = pos_ext - CMP_W'(1);
	assign ins_ok  = (in_cmd == CMD_INSERT) && (cnt_ext < CMP_W'(DEPTH))
		&& (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
	assign rem_ok  = (in_cmd == CMD_REMOVE) && (pos_ext != '0) && (pos_ext <= cnt_ext);
	assign do_moves = (ins_ok && (pos_ext <= cnt_ext)) || (rem_ok && (pos_ext < cnt_ext));

	assign emit_issue = (state_q == ST_EMIT) && (cnt_q != '0) && (emit_ptr_q != cnt_q)
		&& (!pend_s1 || free);
	assign emit_done  = (emit_ptr_q == cnt_q) && (!pend_s1 || free);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (do_moves) begin
						state_d = ST_SHIFT;
					end else if (ins_ok) begin
						state_d = ST_PUT;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SHIFT: begin
				if (rd_ptr_q == rd_end_q) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = (cmd_q == CMD_INSERT) ? ST_PUT : ST_EMIT;
			end
			ST_PUT: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cnt_q == '0) begin
					if (free) begin
						state_d = ST_IDLE;
					end
				end else if (emit_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory and output controls
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_ptr_q;
		we      = 1'b0;
		waddr   = wr_addr_s1;
		wdata   = rdata_q;
		load    = 1'b0;
		res_d.status     = status_q;
		res_d.has_entry  = 1'b1;
		res_d.list_index = idx_s1;
		res_d.isbn       = rdata_q.isbn;
		res_d.year       = rdata_q.year;
		res_d.last       = last_s1;
		case (state_q)
			ST_SHIFT: begin
				rd_en = 1'b1;
			end
			ST_PUT: begin
				we         = 1'b1;
				waddr      = put_addr_q;
				wdata.isbn = isbn_q;
				wdata.year = year_q;
			end
			ST_EMIT: begin
				rd_en   = emit_issue;
				rd_addr = emit_ptr_q[ADDR_W-1:0];
				if (cnt_q == '0) begin
					load             = free;
					res_d.has_entry  = 1'b0;
					res_d.list_index = '0;
					res_d.isbn       = '0;
					res_d.year       = '0;
					res_d.last       = 1'b1;
				end else begin
					load = pend_s1 && free;
				end
			end
			default: begin
			end
		endcase
		if (wr_pend_s1) begin
			we    = 1'b1;
			waddr = wr_addr_s1;
			wdata = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			emit_ptr_q <= '0;
			wr_pend_s1 <= 1'b0;
			pend_s1    <= 1'b0;
		end else begin
			state_q    <= state_d;
			wr_pend_s1 <= (state_q == ST_SHIFT);
			if (accept) begin
				emit_ptr_q <= '0;
				if (ins_ok) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (rem_ok) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end else if (emit_issue) begin
				emit_ptr_q <= emit_ptr_q + CNT_W'(1);
			end
			if (emit_issue) begin
				pend_s1 <= 1'b1;
			end else if (load) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= in_cmd;
			status_q   <= (ins_ok || rem_ok) ? STATUS_DONE : STATUS_REJECT;
			put_addr_q <= pos_m1[ADDR_W-1:0];
			isbn_q     <= in_isbn;
			year_q     <= in_year;
			if (in_cmd == CMD_INSERT) begin
				rd_ptr_q <= cnt_m1[ADDR_W-1:0];
				rd_end_q <= pos_m1[ADDR_W-1:0];
			end else begin
				rd_ptr_q <= pos_ext[ADDR_W-1:0];
				rd_end_q <= cnt_m1[ADDR_W-1:0];
			end
		end else if (state_q == ST_SHIFT) begin
			rd_ptr_q <= (cmd_q == CMD_INSERT) ? rd_ptr_q - ADDR_W'(1) : rd_ptr_q + ADDR_W'(1);
		end
		if (state_q == ST_SHIFT) begin
			wr_addr_s1 <= (cmd_q == CMD_INSERT) ? rd_ptr_q + ADDR_W'(1) : rd_ptr_q - ADDR_W'(1);
		end
		if (emit_issue) begin
			idx_s1  <= POS_W'(emit_ptr_q) + POS_W'(1);
			last_s1 <= (emit_ptr_q + CNT_W'(1) == cnt_q);
		end
	end

	plil_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.din    (res_d),
		.free   (free),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.dout   (res_q)
	);

	assign m_tdata = {1'b0, res_q.year, res_q.isbn, res_q.list_index};
	assign m_tuser = {res_q.has_entry, res_q.status};
	assign m_tlast = res_q.last;

endmodule

>>> design/plil_out_stage.sv
// Output register for result items, decoupling the sequencer from the sink.
// Depends on plil_pkg.
module plil_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  plil_pkg::result_t din,
	output logic              free,
	output logic              valid,
	input  logic              ready,
	output plil_pkg::result_t dout
);
	import plil_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign dout  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_insert_remove: directed and random
// insert/remove commands, output list items checked against a scoreboard prediction.
// Depends on plil_pkg and the design sources.
module tb;
	import plil_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;

	class list_scoreboard;
		logic signed [ID_W-1:0] rec_ids[DEPTH];
		logic [YEAR_W-1:0]      rec_years[DEPTH];
		int unsigned            rec_count;
		result_t                expected_items[$];
		int                     errors;

		function new();
			rec_count = 0;
			errors    = 0;
		endfunction

		function void note_command(logic cmd, logic [POS_W-1:0] pos,
				logic signed [ID_W-1:0] isbn, logic [YEAR_W-1:0] year);
			logic    status;
			result_t r;
			status = STATUS_REJECT;
			if (cmd == CMD_INSERT) begin
				if (rec_count < DEPTH && pos >= 1 && pos <= rec_count + 1) begin
					for (int i = rec_count; i >= pos; i--) begin
						rec_ids[i]   = rec_ids[i-1];
						rec_years[i] = rec_years[i-1];
					end
					rec_ids[pos-1]   = isbn;
					rec_years[pos-1] = year;
					rec_count++;
					status = STATUS_DONE;
				end
			end else begin
				if (pos >= 1 && pos <= rec_count) begin
					for (int i = pos - 1; i + 1 < rec_count; i++) begin
						rec_ids[i]   = rec_ids[i+1];
						rec_years[i] = rec_years[i+1];
					end
					rec_count--;
					status = STATUS_DONE;
				end
			end
			if (rec_count == 0) begin
				r.status     = status;
				r.has_entry  = 1'b0;
				r.list_index = '0;
				r.isbn       = '0;
				r.year       = '0;
				r.last       = 1'b1;
				expected_items.push_back(r);
			end else begin
				for (int i = 0; i < rec_count; i++) begin
					r.status     = status;
					r.has_entry  = 1'b1;
					r.list_index = POS_W'(i + 1);
					r.isbn       = rec_ids[i];
					r.year       = rec_years[i];
					r.last       = (i + 1 == rec_count);
					expected_items.push_back(r);
				end
			end
		endfunction

		task report(string field, logic [31:0] want, logic [31:0] got);
			$display("mismatch %s: expected %0h, got %0h", field, want, got);
			errors++;
		endtask

		task check_item(result_t got);
			result_t want;
			if (expected_items.size() == 0) begin
				report("unexpected item", '0, 32'({got.list_index, got.year}));
			end else begin
				want = expected_items.pop_front();
				if (got.status !== want.status)
					report("status", 32'(want.status), 32'(got.status));
				if (got.has_entry !== want.has_entry)
					report("has_entry", 32'(want.has_entry), 32'(got.has_entry));
				if (got.list_index !== want.list_index)
					report("list_index", 32'(want.list_index), 32'(got.list_index));
				if (got.isbn !== want.isbn)
					report("isbn", want.isbn, got.isbn);
				if (got.year !== want.year)
					report("year", 32'(want.year), 32'(got.year));
				if (got.last !== want.last)
					report("last", 32'(want.last), 32'(got.last));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	list_scoreboard board;
	int             cycle_count = 0;
	int             tx_idle_pct;
	int             rx_idle_pct;
	int             rx_hold;
	bit             growing;

	positional_list_insert_remove DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("positional_list_insert_remove regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			board.note_command(s_tuser[0], s_tdata[6:0], s_tdata[38:7], s_tdata[54:39]);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_item({m_tuser[0], m_tuser[1], m_tdata[6:0], m_tdata[38:7],
				m_tdata[54:39], m_tlast});
	end

	// sink side; a long hold-off is counted down here
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task send_command(input logic cmd, input logic [POS_W-1:0] pos,
			input logic signed [ID_W-1:0] isbn, input logic [YEAR_W-1:0] year);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, year, isbn, pos};
		do @(posedge clk); while (!s_tready);
	endtask

	task drain_results;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.expected_items.size() != 0) @(posedge clk);
	endtask

	// mostly in-range positions; drift toward a full list and back to empty
	task send_random_command;
		logic             cmd;
		logic [POS_W-1:0] pos;
		int               cnt;
		int               r;
		cnt = board.rec_count;
		if (cnt == DEPTH && $urandom_range(1))
			growing = 1'b0;
		if (cnt == 0)
			growing = 1'b1;
		cmd = ($urandom_range(99) < (growing ? 75 : 25)) ? CMD_INSERT : CMD_REMOVE;
		r = $urandom_range(99);
		if (r < 85) begin
			if (cmd == CMD_INSERT)
				pos = POS_W'($urandom_range(cnt + 1, 1));
			else
				pos = (cnt == 0) ? POS_W'(1) : POS_W'($urandom_range(cnt, 1));
		end else if (r < 90) begin
			pos = '0;
		end else if (r < 95) begin
			pos = (cmd == CMD_INSERT) ? POS_W'(cnt + 2) : POS_W'(cnt + 1);
		end else begin
			pos = POS_W'($urandom_range(127));
		end
		send_command(cmd, pos, $urandom, YEAR_W'($urandom_range(65535)));
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		tx_idle_pct = 24;
		rx_idle_pct = 71;
		rx_hold     = 0;
		growing     = 1'b1;
		board       = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty list, bad positions, both ends, middle, extreme records
		send_command(CMD_REMOVE, 1, 0, 0);
		send_command(CMD_INSERT, 0, 32'sd5, 16'd5);
		send_command(CMD_INSERT, 2, 32'sd6, 16'd6);
		send_command(CMD_INSERT, 1, 32'sh7FFFFFFF, 16'hFFFF);
		send_command(CMD_INSERT, 1, 32'sh80000000, 16'h0000);
		send_command(CMD_INSERT, 3, 32'sh12345678, 16'd1999);
		send_command(CMD_INSERT, 2, 32'sh0BADF00D, 16'd2024);
		send_command(CMD_INSERT, 6, 32'sd1, 16'd1);
		send_command(CMD_INSERT, 64, 32'sd2, 16'd2);
		send_command(CMD_INSERT, 127, 32'sd3, 16'd3);
		send_command(CMD_REMOVE, 0, 0, 0);
		send_command(CMD_REMOVE, 5, 0, 0);
		send_command(CMD_REMOVE, 64, 0, 0);
		send_command(CMD_REMOVE, 127, 32'shFFFFFFFF, 16'hFFFF);
		send_command(CMD_REMOVE, 4, 0, 0);
		send_command(CMD_REMOVE, 1, 0, 0);
		send_command(CMD_INSERT, 2, -32'sd1, 16'h5A5A);
		send_command(CMD_REMOVE, 2, 0, 0);
		send_command(CMD_REMOVE, 1, 0, 0);
		send_command(CMD_REMOVE, 1, 0, 0);
		send_command(CMD_REMOVE, 1, 0, 0);

		repeat (43) send_random_command();
		drain_results();

		tx_idle_pct = 71;
		rx_idle_pct = 24;
		repeat (43) send_random_command();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold     = 400;
		repeat (43) send_random_command();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.expected_items.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		if (board.errors == 0 && board.expected_items.size() == 0)
			$display("positional_list_insert_remove regression: pass");
		else
			$display("positional_list_insert_remove regression: fail");
		$finish;
	end

endmodule
